[rtl/ftmd_pkg.sv]
// Shared types, constants and the digit font for the frame time meter.
package ftmd_pkg;

   typedef logic [15:0] row_type;

   // register indexes on the csr port
   localparam logic [1:0] CSR_TICKS_PER_INT  = 2'd0;
   localparam logic [1:0] CSR_TICKS_PER_UNIT = 2'd1;
   localparam logic [1:0] CSR_HYST_FRAMES    = 2'd2;

   localparam logic [15:0] TPI_RESET  = 16'd14186;
   localparam logic [15:0] TPU_RESET  = 16'd1419;
   localparam logic [6:0]  HYST_RESET = 7'd3;

   localparam logic [13:0] SHOW_MAX     = 14'd9999;
   localparam logic [13:0] FINE_MAX     = 14'd999;
   localparam logic [9:0]  COARSE_MAX   = 10'd999;
   localparam logic [15:0] POINT_FINE   = 16'h0400;
   localparam logic [15:0] POINT_COARSE = 16'h0020;

   // x / 10 == (x * 0xCCCD) >> 19 for every x this block produces
   localparam logic [15:0] TENTH_RECIP = 16'hCCCD;

   // shared divider sizes
   localparam int DIV_NUM_W = 33;
   localparam int DIV_DEN_W = 16;
   localparam int DIV_CNT_W = 6;

   localparam int ROW_COUNT = 6;

   // 4x6 font, one nibble per row
   function automatic logic [3:0] font_row(input logic [3:0] digit, input logic [2:0] row);
      logic [23:0] glyph;
      begin
         case (digit)
            4'd0:    glyph = 24'h699996;
            4'd1:    glyph = 24'h262227;
            4'd2:    glyph = 24'h69124F;
            4'd3:    glyph = 24'h692196;
            4'd4:    glyph = 24'h359F11;
            4'd5:    glyph = 24'hF8E196;
            4'd6:    glyph = 24'h78E996;
            4'd7:    glyph = 24'hF11222;
            4'd8:    glyph = 24'h696996;
            4'd9:    glyph = 24'h699716;
            default: glyph = 24'h000000;
         endcase
         case (row)
            3'd0:    font_row = glyph[23:20];
            3'd1:    font_row = glyph[19:16];
            3'd2:    font_row = glyph[15:12];
            3'd3:    font_row = glyph[11:8];
            3'd4:    font_row = glyph[7:4];
            3'd5:    font_row = glyph[3:0];
            default: font_row = 4'h0;
         endcase
      end
   endfunction

endpackage

[rtl/ftmd_div.sv]
// Restoring divider, one quotient bit per cycle.
module ftmd_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ftmd_pkg::DIV_NUM_W-1:0]    num,
   input  logic [ftmd_pkg::DIV_DEN_W-1:0]    den,
   output logic                              done,
   output logic [ftmd_pkg::DIV_NUM_W-1:0]    quo
);

   localparam int NW = ftmd_pkg::DIV_NUM_W;
   localparam int DW = ftmd_pkg::DIV_DEN_W;
   localparam int CW = ftmd_pkg::DIV_CNT_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   trial;
   logic          fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[NW-1]};
      fits    = (trial >= {1'b0, den_ff});
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         // shift the next numerator bit in, subtract when the divisor fits
         rem_in = fits ? DW'(trial - {1'b0, den_ff}) : trial[DW-1:0];
         quo_in = {quo_ff[NW-2:0], fits};
         cnt_in = CW'(cnt_ff + 1'b1);
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

[rtl/frame_time_meter_display.sv]
// Frame time meter: tick repair, window average, hysteresis and digit rendering.
//
// Usage:
//   Present one frame mark per word on the req_ channel (req_valid/req_ready):
//   the down-counting timer reading and the free-running interrupt count.
//   Each accepted word produces exactly one rsp_ word: the filtered frame
//   time in display units, the coarse flag and six 16-bit bitmap rows
//   holding three 4x6 digits plus the decimal point.
//   The restoring divide of the window sum and the 10-step binary to BCD
//   conversion make up most of the work; req_ready is low while one word
//   is in work, so the block takes a new word only after it has finished
//   with the last one.
//   The result sits in an output register; when the receiver stalls
//   (rsp_ready low) the block still returns to idle and accepts the next
//   word, then holds its finished result until the output register frees.
//   Reset (synchronous, active high) loads the register defaults, clears
//   the previous readings, the history window, the running sum, the shown
//   value and the trend counter. No clearing pass is needed. csr_ writes
//   take effect at once; the user makes them only while idle, as nothing checks it.
module frame_time_meter_display #(
   parameter int WINDOW_DEPTH = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_timer_now,
   input  logic [15:0] req_interrupt_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [13:0] rsp_shown_value,
   output logic        rsp_coarse_mode,
   output logic [15:0] rsp_row_0,
   output logic [15:0] rsp_row_1,
   output logic [15:0] rsp_row_2,
   output logic [15:0] rsp_row_3,
   output logic [15:0] rsp_row_4,
   output logic [15:0] rsp_row_5,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int SLOT_W = $clog2(WINDOW_DEPTH);
   localparam int NW     = ftmd_pkg::DIV_NUM_W;
   localparam int DW     = ftmd_pkg::DIV_DEN_W;

   // sequencer codes
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MUL    = 4'd1;
   localparam logic [3:0] S_REPAIR = 4'd2;
   localparam logic [3:0] S_READ   = 4'd3;
   localparam logic [3:0] S_SUB    = 4'd4;
   localparam logic [3:0] S_ACC    = 4'd5;
   localparam logic [3:0] S_ROUND  = 4'd6;
   localparam logic [3:0] S_DIVGO  = 4'd7;
   localparam logic [3:0] S_DIVRUN = 4'd8;
   localparam logic [3:0] S_HYST   = 4'd9;
   localparam logic [3:0] S_SCALE  = 4'd10;
   localparam logic [3:0] S_CAP    = 4'd11;
   localparam logic [3:0] S_BCD    = 4'd12;
   localparam logic [3:0] S_OUT    = 4'd13;

   logic [3:0]              state_ff, state_in;
   logic [15:0]             tpi_ff, tpi_in;
   logic [15:0]             tpu_ff, tpu_in;
   logic [6:0]              hyst_ff, hyst_in;
   logic [15:0]             prev_timer_ff, prev_timer_in;
   logic [15:0]             prev_ints_ff, prev_ints_in;
   logic [15:0]             low_ff, low_in;
   logic [15:0]             delta_ff, delta_in;
   logic [31:0]             est_ff, est_in;
   logic [31:0]             ticks_ff, ticks_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [WINDOW_DEPTH-1:0] hist_vld_ff, hist_vld_in;
   logic [31:0]             hist_rd_ff;
   logic [31:0]             sum_ff, sum_in;
   logic [NW-1:0]           num_ff, num_in;
   logic [DW-1:0]           den_ff, den_in;
   logic [13:0]             val_ff, val_in;
   logic [13:0]             disp_ff, disp_in;
   logic [7:0]              trend_ff, trend_in;
   logic                    coarse_ff, coarse_in;
   logic [30:0]             prod_ff, prod_in;
   logic [9:0]              bin_ff, bin_in;
   logic [11:0]             bcd_ff, bcd_in;
   logic [3:0]              cnt_ff, cnt_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [13:0]             rsp_shown_ff, rsp_shown_in;
   logic                    rsp_coarse_ff, rsp_coarse_in;
   ftmd_pkg::row_type       rsp_rows_ff [ftmd_pkg::ROW_COUNT];
   ftmd_pkg::row_type       rsp_rows_in [ftmd_pkg::ROW_COUNT];
   ftmd_pkg::row_type       rows [ftmd_pkg::ROW_COUNT];

   logic [31:0]             hist_mem [WINDOW_DEPTH];

   logic                    div_start;
   logic                    div_done;
   logic [NW-1:0]           div_quo;

   // repair scratch
   logic [15:0]             est_hi, est_lo, gap, fix_hi;
   // hysteresis scratch
   logic signed [8:0]       trend_s, hyst_s, trend_step;
   // rendering scratch
   logic [11:0]             bcd_adj;
   logic [11:0]             coarse_q;
   logic [14:0]             rounded;
   logic [15:0]             point;

   ftmd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign div_start = (state_ff == S_DIVGO);
   assign req_ready = (state_ff == S_IDLE);

   // nearest tick candidate sharing the low half; ties keep the unshifted one
   always_comb begin
      est_hi = est_ff[31:16];
      est_lo = est_ff[15:0];
      if (est_lo >= low_ff) begin
         gap    = est_lo - low_ff;
         fix_hi = (gap <= 16'h8000) ? est_hi : 16'(est_hi + 1'b1);
      end else begin
         gap    = low_ff - est_lo;
         fix_hi = ((est_hi != 16'h0000) && (gap > 16'h8000)) ? 16'(est_hi - 1'b1) : est_hi;
      end
   end

   // bitmap rows from the three BCD digits
   always_comb begin
      point = coarse_ff ? ftmd_pkg::POINT_COARSE : ftmd_pkg::POINT_FINE;
      for (int r = 0; r < ftmd_pkg::ROW_COUNT; r++) begin
         rows[r] = {ftmd_pkg::font_row(bcd_ff[11:8], 3'(r)), 12'h000}
                 | (16'(ftmd_pkg::font_row(bcd_ff[7:4], 3'(r))) << (coarse_ff ? 7 : 5))
                 | 16'(ftmd_pkg::font_row(bcd_ff[3:0], 3'(r)));
         if (r == ftmd_pkg::ROW_COUNT - 1) begin
            rows[r] = rows[r] | point;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      tpi_in        = tpi_ff;
      tpu_in        = tpu_ff;
      hyst_in       = hyst_ff;
      prev_timer_in = prev_timer_ff;
      prev_ints_in  = prev_ints_ff;
      low_in        = low_ff;
      delta_in      = delta_ff;
      est_in        = est_ff;
      ticks_in      = ticks_ff;
      slot_in       = slot_ff;
      hist_vld_in   = hist_vld_ff;
      sum_in        = sum_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      val_in        = val_ff;
      disp_in       = disp_ff;
      trend_in      = trend_ff;
      coarse_in     = coarse_ff;
      prod_in       = prod_ff;
      bin_in        = bin_ff;
      bcd_in        = bcd_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_shown_in  = rsp_shown_ff;
      rsp_coarse_in = rsp_coarse_ff;
      rsp_rows_in   = rsp_rows_ff;

      trend_s    = $signed({trend_ff[7], trend_ff});
      hyst_s     = $signed({2'b00, hyst_ff});
      trend_step = trend_s;
      rounded    = 15'(disp_ff) + 15'd5;
      coarse_q   = prod_ff[30:19];
      bcd_adj    = bcd_ff;

      // register writes; indexes beyond the list fall through
      if (csr_we) begin
         case (csr_index)
            ftmd_pkg::CSR_TICKS_PER_INT:  tpi_in  = csr_wdata;
            ftmd_pkg::CSR_TICKS_PER_UNIT: tpu_in  = csr_wdata;
            ftmd_pkg::CSR_HYST_FRAMES:    hyst_in = csr_wdata[6:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               low_in        = prev_timer_ff - req_timer_now;
               delta_in      = req_interrupt_count - prev_ints_ff;
               prev_timer_in = req_timer_now;
               prev_ints_in  = req_interrupt_count;
               state_in      = S_MUL;
            end
         end
         S_MUL: begin
            // scaled interrupt delta: rough estimate of elapsed ticks
            est_in   = 32'(delta_ff) * 32'(tpi_ff);
            state_in = S_REPAIR;
         end
         S_REPAIR: begin
            ticks_in = {fix_hi, low_ff};
            state_in = S_READ;
         end
         S_READ: begin
            // memory read of the slot being replaced lands in hist_rd_ff
            state_in = S_SUB;
         end
         S_SUB: begin
            // drop the oldest entry; never written reads as zero
            sum_in   = sum_ff - (hist_vld_ff[slot_ff] ? hist_rd_ff : 32'd0);
            state_in = S_ACC;
         end
         S_ACC: begin
            sum_in               = sum_ff + ticks_ff;
            hist_vld_in[slot_ff] = 1'b1;
            slot_in              = (slot_ff == SLOT_W'(WINDOW_DEPTH - 1)) ?
                                   '0 : SLOT_W'(slot_ff + 1'b1);
            state_in             = S_ROUND;
         end
         S_ROUND: begin
            // zero divisor acts as one; rounding addend kept in 33 bits
            den_in   = (tpu_ff == 16'd0) ? 16'd1 : tpu_ff;
            num_in   = NW'(sum_ff) + NW'(((tpu_ff == 16'd0) ? 16'd1 : tpu_ff) >> 1);
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            state_in = S_DIVRUN;
         end
         S_DIVRUN: begin
            if (div_done) begin
               val_in   = (div_quo > NW'(ftmd_pkg::SHOW_MAX)) ?
                          ftmd_pkg::SHOW_MAX : div_quo[13:0];
               state_in = S_HYST;
            end
         end
         S_HYST: begin
            if (val_ff < disp_ff) begin
               trend_step = trend_s - 9'sd1;
               trend_in   = trend_step[7:0];
               if (trend_step <= -hyst_s) begin
                  disp_in  = val_ff;
                  trend_in = 8'(-hyst_s);
               end
            end else if (val_ff > disp_ff) begin
               trend_step = trend_s + 9'sd1;
               trend_in   = trend_step[7:0];
               if (trend_step >= hyst_s) begin
                  disp_in  = val_ff;
                  trend_in = hyst_s[7:0];
               end
            end
            state_in = S_SCALE;
         end
         S_SCALE: begin
            coarse_in = (disp_ff > ftmd_pkg::FINE_MAX);
            prod_in   = 31'(rounded) * 31'(ftmd_pkg::TENTH_RECIP);
            state_in  = S_CAP;
         end
         S_CAP: begin
            if (coarse_ff) begin
               bin_in = (coarse_q > 12'(ftmd_pkg::COARSE_MAX)) ?
                        ftmd_pkg::COARSE_MAX : coarse_q[9:0];
            end else begin
               bin_in = disp_ff[9:0];
            end
            bcd_in   = '0;
            cnt_in   = '0;
            state_in = S_BCD;
         end
         S_BCD: begin
            // double dabble: adjust each digit, then shift one bit in
            for (int n = 0; n < 3; n++) begin
               if (bcd_ff[4*n +: 4] >= 4'd5) begin
                  bcd_adj[4*n +: 4] = 4'(bcd_ff[4*n +: 4] + 4'd3);
               end
            end
            bcd_in = {bcd_adj[10:0], bin_ff[9]};
            bin_in = {bin_ff[8:0], 1'b0};
            cnt_in = 4'(cnt_ff + 1'b1);
            if (cnt_ff == 4'd9) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold here until the output register frees
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_shown_in  = disp_ff;
               rsp_coarse_in = coarse_ff;
               rsp_rows_in   = rows;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tpi_ff        <= ftmd_pkg::TPI_RESET;
         tpu_ff        <= ftmd_pkg::TPU_RESET;
         hyst_ff       <= ftmd_pkg::HYST_RESET;
         prev_timer_ff <= '0;
         prev_ints_ff  <= '0;
         slot_ff       <= '0;
         hist_vld_ff   <= '0;
         sum_ff        <= '0;
         disp_ff       <= '0;
         trend_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tpi_ff        <= tpi_in;
         tpu_ff        <= tpu_in;
         hyst_ff       <= hyst_in;
         prev_timer_ff <= prev_timer_in;
         prev_ints_ff  <= prev_ints_in;
         slot_ff       <= slot_in;
         hist_vld_ff   <= hist_vld_in;
         sum_ff        <= sum_in;
         disp_ff       <= disp_in;
         trend_ff      <= trend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      low_ff        <= low_in;
      delta_ff      <= delta_in;
      est_ff        <= est_in;
      ticks_ff      <= ticks_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      val_ff        <= val_in;
      coarse_ff     <= coarse_in;
      prod_ff       <= prod_in;
      bin_ff        <= bin_in;
      bcd_ff        <= bcd_in;
      cnt_ff        <= cnt_in;
      rsp_shown_ff  <= rsp_shown_in;
      rsp_coarse_ff <= rsp_coarse_in;
      rsp_rows_ff   <= rsp_rows_in;
   end

   // history window memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == S_ACC) begin
         hist_mem[slot_ff] <= ticks_ff;
      end
      if (state_ff == S_READ) begin
         hist_rd_ff <= hist_mem[slot_ff];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_shown_value = rsp_shown_ff;
   assign rsp_coarse_mode = rsp_coarse_ff;
   assign rsp_row_0       = rsp_rows_ff[0];
   assign rsp_row_1       = rsp_rows_ff[1];
   assign rsp_row_2       = rsp_rows_ff[2];
   assign rsp_row_3       = rsp_rows_ff[3];
   assign rsp_row_4       = rsp_rows_ff[4];
   assign rsp_row_5       = rsp_rows_ff[5];

endmodule

[bench/tb_frame_time_meter_display.sv]
// Self-checking testbench for frame_time_meter_display: scoreboard class and driving tasks.
`timescale 1ns / 1ps

typedef struct packed {
   logic [13:0]      shown;
   logic             coarse;
   logic [5:0][15:0] rows;
} readout_type;

class frame_meter_scoreboard;
   localparam int HISTORY_DEPTH = 10;

   logic [15:0] tpi;
   logic [15:0] tpu;
   logic [6:0]  hyst;
   logic [15:0] last_timer;
   logic [15:0] last_irq;
   logic [31:0] history [HISTORY_DEPTH];
   logic [31:0] window_total;
   int          slot;
   logic [13:0] shown;
   int          trend;
   readout_type expected_readouts [$];
   int unsigned frames, compared, coarse_seen, saturated_seen, capped_seen, faults;

   function new();
      tpi = ftmd_pkg::TPI_RESET;
      tpu = ftmd_pkg::TPU_RESET;
      hyst = ftmd_pkg::HYST_RESET;
      last_timer = '0;
      last_irq = '0;
      foreach (history[k]) history[k] = '0;
      window_total = '0;
      slot = 0;
      shown = '0;
      trend = 0;
      frames = 0;
      compared = 0;
      coarse_seen = 0;
      saturated_seen = 0;
      capped_seen = 0;
      faults = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
         ftmd_pkg::CSR_TICKS_PER_INT:  tpi = data;
         ftmd_pkg::CSR_TICKS_PER_UNIT: tpu = data;
         ftmd_pkg::CSR_HYST_FRAMES:    hyst = data[6:0];
         default: ;
      endcase
   endfunction

   // 4x6 digit font, top row in the high nibble
   function logic [3:0] glyph_row(int unsigned digit, int row);
      logic [23:0] g;
      case (digit)
         0: g = 24'h699996;
         1: g = 24'h262227;
         2: g = 24'h69124F;
         3: g = 24'h692196;
         4: g = 24'h359F11;
         5: g = 24'hF8E196;
         6: g = 24'h78E996;
         7: g = 24'hF11222;
         8: g = 24'h696996;
         default: g = 24'h699716;
      endcase
      return g[23 - 4 * row -: 4];
   endfunction

   // pick the candidate sharing the low half that lies nearest the estimate
   function logic [31:0] nearest_ticks(logic [31:0] low, logic [31:0] est);
      logic [31:0] c1, c2;
      c1 = {est[31:16], low[15:0]};
      if (est >= c1) begin
         c2 = c1 + 32'h10000;
         return ((est - c1) <= (c2 - est)) ? c1 : c2;
      end
      if (c1 >= 32'h10000) begin
         c2 = c1 - 32'h10000;
         return ((c1 - est) <= (est - c2)) ? c1 : c2;
      end
      return c1;
   endfunction

   function void predict_readout(logic [15:0] timer, logic [15:0] irq);
      logic [15:0] low16, dirq, point;
      logic [31:0] est, ticks, div;
      logic [63:0] q;
      logic [13:0] val;
      int          h;
      int unsigned v, sh, d1, d2, d3;
      readout_type r;
      low16 = last_timer - timer;
      dirq = irq - last_irq;
      last_timer = timer;
      last_irq = irq;
      est = {16'd0, dirq} * {16'd0, tpi};
      ticks = nearest_ticks({16'd0, low16}, est);

      window_total = window_total - history[slot] + ticks;
      history[slot] = ticks;
      slot = (slot + 1) % HISTORY_DEPTH;

      div = (tpu == 16'd0) ? 32'd1 : {16'd0, tpu};
      q = ({32'd0, window_total} + {33'd0, div[31:1]}) / {32'd0, div};
      if (q > 64'd9999) begin
         val = ftmd_pkg::SHOW_MAX;
         saturated_seen++;
      end else begin
         val = q[13:0];
      end

      h = int'(hyst);
      if (val < shown) begin
         trend--;
         if (trend <= -h) begin
            shown = val;
            trend = -h;
         end
      end else if (val > shown) begin
         trend++;
         if (trend >= h) begin
            shown = val;
            trend = h;
         end
      end

      r.shown = shown;
      if (shown <= ftmd_pkg::FINE_MAX) begin
         v = shown;
         sh = 5;
         point = ftmd_pkg::POINT_FINE;
         r.coarse = 1'b0;
      end else begin
         v = (int'(shown) + 5) / 10;
         if (v > ftmd_pkg::COARSE_MAX) begin
            v = ftmd_pkg::COARSE_MAX;
            capped_seen++;
         end
         sh = 7;
         point = ftmd_pkg::POINT_COARSE;
         r.coarse = 1'b1;
         coarse_seen++;
      end
      d3 = v % 10;
      d2 = (v / 10) % 10;
      d1 = (v / 100) % 10;
      for (int k = 0; k < 6; k++) begin
         r.rows[k] = ({12'd0, glyph_row(d1, k)} << 12) | ({12'd0, glyph_row(d2, k)} << sh) |
                     {12'd0, glyph_row(d3, k)};
         if (k == 5) r.rows[k] = r.rows[k] | point;
      end
      expected_readouts.push_back(r);
   endfunction

   function void note_frame(logic [15:0] timer, logic [15:0] irq);
      frames++;
      predict_readout(timer, irq);
   endfunction

   function void fault(string what);
      faults++;
      if (faults <= 10) $display("%s", what);
   endfunction

   function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got)
         fault($sformatf("readout %0d: %s expected %h, got %h", compared, name, want, got));
   endfunction

   function void check_readout(readout_type got);
      readout_type want;
      if (expected_readouts.size() == 0) begin
         fault($sformatf("readout %h arrived with nothing expected", got));
         return;
      end
      want = expected_readouts.pop_front();
      compare_field("shown_value", 16'(want.shown), 16'(got.shown));
      compare_field("coarse_mode", 16'(want.coarse), 16'(got.coarse));
      for (int k = 0; k < 6; k++)
         compare_field($sformatf("row_%0d", k), want.rows[k], got.rows[k]);
      compared++;
   endfunction

   function int unsigned pending();
      return expected_readouts.size();
   endfunction
endclass

module tb_frame_time_meter_display;
   localparam logic [1:0] CSR_SPARE = 2'd3;    // index past the register list
   localparam int GAP_MAX     = 14;
   localparam int STALL_LIMIT = 3000;          // cycles without any accepted word
   localparam int HOLD_OFF    = 400;           // long receiver stall, fills the block
   localparam int TAIL        = 120;           // slack after the drain for late readouts
   localparam int RAMP_LEN    = 135;           // takes the trend to its clamp of 127
   localparam int PHASES      = 6;
   localparam int PHASE_LEN   = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [15:0] req_timer_now = '0;
   logic [15:0] req_interrupt_count = '0;
   logic        rsp_ready = 1'b0;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic        req_ready;
   logic        rsp_valid;
   logic [13:0] rsp_shown_value;
   logic        rsp_coarse_mode;
   logic [15:0] rsp_row_0, rsp_row_1, rsp_row_2, rsp_row_3, rsp_row_4, rsp_row_5;
   readout_type rsp_word;

   frame_meter_scoreboard sb = new();

   // running timer and interrupt positions the next frame mark builds on
   logic [15:0] timer_pos = '0;
   logic [15:0] irq_pos = '0;
   int unsigned words_sent = 0;
   int unsigned readouts_taken = 0;
   int unsigned settings = 1;
   int          idle_cycles = 0;

   frame_time_meter_display dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_timer_now       (req_timer_now),
      .req_interrupt_count (req_interrupt_count),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_shown_value     (rsp_shown_value),
      .rsp_coarse_mode     (rsp_coarse_mode),
      .rsp_row_0           (rsp_row_0),
      .rsp_row_1           (rsp_row_1),
      .rsp_row_2           (rsp_row_2),
      .rsp_row_3           (rsp_row_3),
      .rsp_row_4           (rsp_row_4),
      .rsp_row_5           (rsp_row_5),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #2 clock = ~clock;

   assign rsp_word = {rsp_shown_value, rsp_coarse_mode, rsp_row_5, rsp_row_4,
                      rsp_row_3, rsp_row_2, rsp_row_1, rsp_row_0};

   // Sample both channels at the edge (pre-edge values, since every drive is
   // nonblocking), feed the scoreboard and watch for a hung block.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_frame(req_timer_now, req_interrupt_count);
         if (rsp_valid && rsp_ready) sb.check_readout(rsp_word);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("no word moved for %0d cycles, %0d readouts still owed",
                     STALL_LIMIT, sb.pending());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Idle draw shared by both sides: every fourth run of 16 words goes flat out.
   function automatic int unsigned draw_pause(int unsigned count);
      if ((count / 16) % 4 == 1) return 0;
      return $urandom_range(0, GAP_MAX);
   endfunction

   // Receiver: stall a random number of cycles before each readout, and once
   // hold off for a long stretch so the block fills and backs up its input.
   initial begin
      int unsigned n;
      while (reset) @(posedge clock);
      forever begin
         n = (readouts_taken == 60) ? HOLD_OFF : draw_pause(readouts_taken);
         if (n != 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         readouts_taken++;
      end
   end

   // Offer one word and hold it until taken; valid stays up into the next call.
   task automatic offer_frame(input logic [15:0] timer, input logic [15:0] irq);
      int unsigned n;
      n = draw_pause(words_sent);
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_timer_now <= timer;
      req_interrupt_count <= irq;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // Advance the timer down by the low step and the interrupt count up.
   task automatic step_frame(input logic [15:0] low_step, input logic [15:0] irq_step);
      timer_pos = timer_pos - low_step;
      irq_pos = irq_pos + irq_step;
      offer_frame(timer_pos, irq_pos);
   endtask

   // A well-formed frame: interrupt delta matches the elapsed ticks, give or take jitter.
   task automatic natural_frame(input int unsigned elapsed, input int jitter);
      int unsigned per_irq;
      int          ints;
      per_irq = (sb.tpi == 16'd0) ? 1 : int'(sb.tpi);
      ints = int'((elapsed + per_irq / 2) / per_irq) + jitter;
      step_frame(elapsed[15:0], 16'(ints));
   endtask

   // Drop valid and wait until every readout owed has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
   endtask

   // Reprogram all registers with the block idle; also poke the unused index.
   task automatic configure(input logic [15:0] tpi, input logic [15:0] tpu,
                            input logic [15:0] hyst_data);
      drain();
      write_reg(ftmd_pkg::CSR_TICKS_PER_INT, tpi);
      write_reg(ftmd_pkg::CSR_TICKS_PER_UNIT, tpu);
      write_reg(ftmd_pkg::CSR_HYST_FRAMES, hyst_data);
      write_reg(CSR_SPARE, 16'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
      settings++;
   endtask

   initial begin
      logic [15:0] tpi, tpu;
      logic [6:0]  h;
      longint unsigned span;
      int unsigned kind, target;
      int          jitter;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: field extremes, then a few ordinary frames.
      offer_frame(16'h0000, 16'h0000);
      offer_frame(16'hFFFF, 16'hFFFF);
      offer_frame(16'h0000, 16'h0000);
      natural_frame(283720, 0);
      natural_frame(14186, 1);
      natural_frame(70000, 0);
      natural_frame(1500000, -1);

      // One tick per interrupt, zero divisor, zero hysteresis (upper data bits
      // set to check that only seven bits land).
      configure(16'd1, 16'd0, 16'hFF80);
      step_frame(16'h0000, 16'h8000);   // tie above: keep the unshifted candidate
      step_frame(16'h0000, 16'h8001);   // just past the tie: take the next one up
      step_frame(16'h0100, 16'h0010);   // estimate under the only candidate
      step_frame(16'hFFFF, 16'h0000);   // largest low half, no interrupts

      // Two ticks per interrupt puts the estimate at 64K for the lower branch.
      configure(16'd2, 16'd0, 16'hFF80);
      step_frame(16'h8000, 16'h8000);   // tie below: keep the unshifted candidate
      step_frame(16'h8001, 16'h8000);   // nearer the shifted-down candidate
      step_frame(16'h7FFF, 16'h8000);
      // Flush the window with zero frames so the shown value drops to zero.
      repeat (10) step_frame(16'h0000, 16'h0000);

      // Steadily rising frame times at the widest hysteresis: the shown value
      // moves after 127 frames, and the trend then runs into its clamp.
      configure(16'hFFFF, 16'd1000, {9'h1FF, 7'd127});
      for (int k = 1; k <= RAMP_LEN; k++)
         natural_frame(2000 * k + $urandom_range(0, 1999), 0);

      // Random settings; mostly well-formed frames around a random display
      // level, plus raw noise and frames with a broken interrupt count.
      for (int p = 0; p < PHASES; p++) begin
         case ($urandom_range(0, 3))
            0:       tpi = 16'd1;
            1:       tpi = 16'hFFFF;
            2:       tpi = ftmd_pkg::TPI_RESET;
            default: tpi = 16'($urandom_range(1, 65535));
         endcase
         if (p == 0)
            tpu = 16'hFFFF;
         else if (p == 1)
            tpu = 16'd1;
         else if ($urandom_range(0, 1) == 0)
            tpu = 16'($urandom_range(1, 300));
         else
            tpu = 16'($urandom_range(1, 65535));
         if (p == 2)
            h = 7'd0;
         else if (p == 3)
            h = 7'd127;
         else
            h = 7'($urandom_range(1, 6));
         configure(tpi, tpu, {9'($urandom), h});

         target = $urandom_range(0, 12000);
         span = longint'(target) * longint'(tpu) / 5;
         if (span > 4000000) span = 4000000;
         if (span == 0) span = 1;
         for (int i = 0; i < PHASE_LEN; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 85) begin
               jitter = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 2)) - 1 : 0;
               natural_frame($urandom_range(0, int'(span)), jitter);
            end else if (kind < 93) begin
               timer_pos = 16'($urandom);
               irq_pos = 16'($urandom);
               offer_frame(timer_pos, irq_pos);
            end else begin
               step_frame(16'($urandom_range(0, 2000)), 16'($urandom));
            end
         end
      end

      // Wait out anything late, then count leftovers.
      drain();
      repeat (TAIL) @(posedge clock);
      if (sb.pending() != 0) sb.fault($sformatf("%0d readouts never arrived", sb.pending()));

      $display("%0d frame marks over %0d register settings, %0d readouts compared",
               sb.frames, settings, sb.compared);
      $display("%0d coarse readouts, %0d saturated averages, %0d at the coarse cap; %0d faults",
               sb.coarse_seen, sb.saturated_seen, sb.capped_seen, sb.faults);
      if (sb.faults == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
